// ----- rtl/hsbd_pkg.sv -----
// Shared constants, types and state codes of the shot boundary detector.
// No dependencies; hsbd_if, hsbd_front, hsbd_queue, hsbd_back and the top level import it.
package hsbd_pkg;

  localparam int BINS_PER_CHANNEL_DEF = 32;
  localparam int MAX_FRAME_PIXELS_DEF = 2097152;

  localparam int PIX_W       = 8;
  localparam int DIST_W      = 28;
  localparam int PERIOD_W    = 16;
  localparam int QUEUE_DEPTH = 4;

  // Q1.30 fractions, quotient up to and including 1.0
  localparam int FRAC_SHIFT = 30;
  localparam int FRAC_W     = FRAC_SHIFT + 1;
  localparam int SUM_W      = FRAC_W + 1;
  localparam int PROD_W     = 2 * FRAC_W;
  // term = d^2 / (s << 6), always below 2^26
  localparam int TERM_SHIFT = 6;
  localparam int TERM_QW    = 26;
  localparam int TERM_DW    = SUM_W + TERM_SHIFT;

  localparam logic [DIST_W-1:0] DIST_MAX      = '1;
  localparam logic [DIST_W-1:0] THRESHOLD_RST = 28'd8388608;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DIST_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 1'b0,
    CFG_KEY_INTERVAL = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [DIST_W-1:0]   threshold;
    logic [PERIOD_W-1:0] key_interval;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              above_threshold;
    logic              shot_end;
    logic              shot_start;
    logic              keyframe;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WR,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_FRAC,
    ST_DIFF,
    ST_MUL,
    ST_TERM_GO,
    ST_TERM,
    ST_NEXT,
    ST_EMIT
  } bk_state_t;

endpackage

// ----- rtl/hsbd_if.sv -----
// Pixel and result channel interfaces, valid/ready handshake.
// Depends on hsbd_pkg for field widths.
interface hsbd_pix_if import hsbd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_c0;
  logic [PIX_W-1:0] pixel_c1;
  logic [PIX_W-1:0] pixel_c2;
  logic             frame_last;

  modport source (output valid, output pixel_c0, output pixel_c1, output pixel_c2,
                  output frame_last, input ready);
  modport sink   (input valid, input pixel_c0, input pixel_c1, input pixel_c2,
                  input frame_last, output ready);
endinterface

interface hsbd_res_if import hsbd_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              above_threshold;
  logic              shot_end;
  logic              shot_start;
  logic              keyframe;

  modport source (output valid, output distance, output above_threshold,
                  output shot_end, output shot_start, output keyframe, input ready);
  modport sink   (input valid, input distance, input above_threshold,
                  input shot_end, input shot_start, input keyframe, output ready);
endinterface

// ----- rtl/hsbd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hsbd_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/hsbd_sdiv.sv -----
// Restoring divider, one quotient bit per cycle.
// Needs rem_init < divisor; no dependencies.
module hsbd_sdiv #(
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem_init,
  input  logic [QW-1:0] low_bits,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quo
);
  localparam int CNT_W = $clog2(QW + 1);

  logic [DW-1:0]    rem_r;
  logic [QW-1:0]    low_r;
  logic [QW-1:0]    quo_r;
  logic [DW-1:0]    div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  assign trial = {rem_r, low_r[QW-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(QW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      low_r <= low_bits;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low_r <= low_r << 1;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
endmodule

// ----- rtl/hsbd_front.sv -----
// Front end: takes pixels, works out the histogram bin and hands it on.
// Depends on hsbd_pkg and hsbd_pix_if.
module hsbd_front import hsbd_pkg::*; #(
  parameter int BINS_PER_CHANNEL = BINS_PER_CHANNEL_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hsbd_pix_if.sink              pix,
  input  logic                  enable,
  output logic                  push,
  output logic [$clog2(BINS_PER_CHANNEL*BINS_PER_CHANNEL*BINS_PER_CHANNEL)-1:0] push_idx,
  output logic                  push_last,
  input  logic                  push_ok
);
  localparam int NB    = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
  localparam int IDX_W = $clog2(NB);
  localparam int BIN_W = $clog2(BINS_PER_CHANNEL);
  localparam int MUL_W = PIX_W + 8;

  logic             vld_r;
  logic [IDX_W-1:0] idx_r;
  logic             last_r;
  logic             take;
  logic [MUL_W-1:0] p0, p1, p2;
  logic [BIN_W-1:0] b0, b1, b2;
  logic [IDX_W-1:0] idx;

  // bin = (c * bins) >> 8
  assign p0  = MUL_W'(pix.pixel_c0) * MUL_W'(BINS_PER_CHANNEL);
  assign p1  = MUL_W'(pix.pixel_c1) * MUL_W'(BINS_PER_CHANNEL);
  assign p2  = MUL_W'(pix.pixel_c2) * MUL_W'(BINS_PER_CHANNEL);
  assign b0  = BIN_W'(p0 >> PIX_W);
  assign b1  = BIN_W'(p1 >> PIX_W);
  assign b2  = BIN_W'(p2 >> PIX_W);
  assign idx = (IDX_W'(b0) * IDX_W'(BINS_PER_CHANNEL) + IDX_W'(b1))
               * IDX_W'(BINS_PER_CHANNEL) + IDX_W'(b2);

  assign pix.ready = enable && (!vld_r || push_ok);
  assign take      = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (take) begin
      vld_r <= 1'b1;
    end else if (push_ok) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idx_r  <= idx;
      last_r <= pix.frame_last;
    end
  end

  assign push      = vld_r;
  assign push_idx  = idx_r;
  assign push_last = last_r;
endmodule

// ----- rtl/hsbd_queue.sv -----
// Short FIFO between front end and histogram engine.
// No dependencies beyond hsbd_pkg for the default depth.
module hsbd_queue import hsbd_pkg::*; #(
  parameter int W     = 16,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         push_ok,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign push_ok = cnt_r != (AW+1)'(DEPTH);
  assign valid   = cnt_r != '0;
  assign do_push = push && push_ok;
  assign do_pop  = pop && valid;
  assign rdata   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end
endmodule

// ----- rtl/hsbd_back.sv -----
// Histogram engine: bin updates, frame-end chi-square walk, shot decisions.
// Depends on hsbd_pkg, hsbd_ram and hsbd_sdiv.
module hsbd_back import hsbd_pkg::*; #(
  parameter int BINS_PER_CHANNEL = BINS_PER_CHANNEL_DEF,
  parameter int MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  logic [$clog2(BINS_PER_CHANNEL*BINS_PER_CHANNEL*BINS_PER_CHANNEL)-1:0] q_idx,
  input  logic q_last,
  output logic q_pop,
  input  cfg_t cfg,
  output logic res_valid,
  input  logic res_ready,
  output res_t res,
  output logic clearing
);
  localparam int NB    = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
  localparam int IDX_W = $clog2(NB);
  localparam int CW    = $clog2(MAX_FRAME_PIXELS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NB - 1);
  localparam logic [CW-1:0]    MAXC     = CW'(MAX_FRAME_PIXELS);

  bk_state_t state_r, state_nxt;
  logic              sel_r, sel_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              last_r, last_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [CW-1:0]     cur_cnt_r, cur_cnt_nxt;
  logic [CW-1:0]     prev_cnt_r, prev_cnt_nxt;
  logic              first_r, first_nxt;
  logic              prev_above_r, prev_above_nxt;
  logic              start_rec_r, start_rec_nxt;
  logic [PERIOD_W-1:0] fsm_r, fsm_nxt;
  logic [DIST_W-1:0] acc_r, acc_nxt;
  logic [FRAC_W-1:0] a_r, a_nxt, b_r, b_nxt, d_r, d_nxt;
  logic [SUM_W-1:0]  s_r, s_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  res_t              res_r, res_nxt;
  logic              res_valid_r, res_valid_nxt;

  logic              we0, we1;
  logic [IDX_W-1:0]  raddr, waddr;
  logic [CW-1:0]     wdata, rd0, rd1, cur_rd, prev_rd;
  logic              f_start, t_start, fa_busy, fb_busy, t_busy;
  logic [FRAC_W-1:0] fa_quo, fb_quo;
  logic [TERM_QW-1:0] t_quo;

  assign cur_rd  = sel_r ? rd1 : rd0;
  assign prev_rd = sel_r ? rd0 : rd1;

  hsbd_ram #(.W(CW), .DEPTH(NB)) u_bank0 (
    .clk, .we(we0), .waddr, .wdata, .raddr, .rdata(rd0)
  );
  hsbd_ram #(.W(CW), .DEPTH(NB)) u_bank1 (
    .clk, .we(we1), .waddr, .wdata, .raddr, .rdata(rd1)
  );

  // a = prev_bin * 2^30 / prev_count, b likewise for the current frame
  hsbd_sdiv #(.DW(CW), .QW(FRAC_W)) u_div_a (
    .clk, .rst_n, .start(f_start),
    .rem_init(CW'(prev_rd >> 1)),
    .low_bits({prev_rd[0], {FRAC_SHIFT{1'b0}}}),
    .divisor(prev_cnt_r), .busy(fa_busy), .quo(fa_quo)
  );
  hsbd_sdiv #(.DW(CW), .QW(FRAC_W)) u_div_b (
    .clk, .rst_n, .start(f_start),
    .rem_init(CW'(cur_rd >> 1)),
    .low_bits({cur_rd[0], {FRAC_SHIFT{1'b0}}}),
    .divisor(cur_cnt_r), .busy(fb_busy), .quo(fb_quo)
  );
  hsbd_sdiv #(.DW(TERM_DW), .QW(TERM_QW)) u_div_t (
    .clk, .rst_n, .start(t_start),
    .rem_init(TERM_DW'(prod_r >> TERM_QW)),
    .low_bits(prod_r[TERM_QW-1:0]),
    .divisor({s_r, {TERM_SHIFT{1'b0}}}), .busy(t_busy), .quo(t_quo)
  );

  always_comb begin
    logic [DIST_W:0]     acc_sum;
    logic                st, en, ab, key, sr;
    logic [PERIOD_W-1:0] f1;

    state_nxt      = state_r;
    sel_nxt        = sel_r;
    idx_nxt        = idx_r;
    last_nxt       = last_r;
    ptr_nxt        = ptr_r;
    cur_cnt_nxt    = cur_cnt_r;
    prev_cnt_nxt   = prev_cnt_r;
    first_nxt      = first_r;
    prev_above_nxt = prev_above_r;
    start_rec_nxt  = start_rec_r;
    fsm_nxt        = fsm_r;
    acc_nxt        = acc_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    d_nxt          = d_r;
    s_nxt          = s_r;
    prod_nxt       = prod_r;
    res_nxt        = res_r;
    res_valid_nxt  = res_valid_r;
    q_pop          = 1'b0;
    we0            = 1'b0;
    we1            = 1'b0;
    raddr          = ptr_r;
    waddr          = ptr_r;
    wdata          = '0;
    f_start        = 1'b0;
    t_start        = 1'b0;
    acc_sum        = {1'b0, acc_r} + (DIST_W+1)'(t_quo);
    st             = 1'b0;
    en             = 1'b0;
    ab             = 1'b0;
    key            = 1'b0;
    sr             = start_rec_r;
    f1             = fsm_r;

    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        we0 = 1'b1;
        we1 = 1'b1;
        if (ptr_r == LAST_IDX) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        raddr = q_idx;
        if (q_valid) begin
          q_pop     = 1'b1;
          idx_nxt   = q_idx;
          last_nxt  = q_last;
          state_nxt = ST_PIX_WR;
        end
      end
      ST_PIX_WR: begin
        waddr = idx_r;
        wdata = (cur_rd < MAXC) ? cur_rd + CW'(1) : cur_rd;
        we0   = !sel_r;
        we1   = sel_r;
        if (cur_cnt_r < MAXC) begin
          cur_cnt_nxt = cur_cnt_r + CW'(1);
        end
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (first_r) begin
          state_nxt = ST_EMIT;
        end else begin
          ptr_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        // old previous bank is cleared behind the walk; it becomes current
        we0 = sel_r;
        we1 = !sel_r;
        if (prev_rd == '0 && cur_rd == '0) begin
          if (ptr_r == LAST_IDX) begin
            state_nxt = ST_EMIT;
          end else begin
            ptr_nxt   = ptr_r + IDX_W'(1);
            state_nxt = ST_WALK_RD;
          end
        end else begin
          f_start   = 1'b1;
          state_nxt = ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (!fa_busy) begin
          a_nxt     = (prev_cnt_r == '0) ? '0 : fa_quo;
          b_nxt     = (cur_cnt_r == '0) ? '0 : fb_quo;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        d_nxt     = (a_r > b_r) ? a_r - b_r : b_r - a_r;
        s_nxt     = SUM_W'(a_r) + SUM_W'(b_r);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = d_r * d_r;
        state_nxt = (d_r == '0) ? ST_NEXT : ST_TERM_GO;
      end
      ST_TERM_GO: begin
        t_start   = 1'b1;
        state_nxt = ST_TERM;
      end
      ST_TERM: begin
        if (!t_busy) begin
          acc_nxt   = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (ptr_r == LAST_IDX) begin
          state_nxt = ST_EMIT;
        end else begin
          ptr_nxt   = ptr_r + IDX_W'(1);
          state_nxt = ST_WALK_RD;
        end
      end
      ST_EMIT: begin
        if (!res_valid_r || res_ready) begin
          if (first_r) begin
            res_nxt        = '{distance: '0, above_threshold: 1'b0, shot_end: 1'b0,
                               shot_start: 1'b1, keyframe: 1'b0};
            first_nxt      = 1'b0;
            start_rec_nxt  = 1'b1;
            prev_above_nxt = 1'b0;
            fsm_nxt        = '0;
          end else begin
            // start check, then end check, then keyframe check
            st = prev_above_r && !start_rec_r;
            if (st) begin
              sr = 1'b1;
              f1 = '0;
            end
            ab = acc_r > cfg.threshold;
            en = ab && !prev_above_r;
            if (en) begin
              sr = 1'b0;
              f1 = '0;
            end
            key = (cfg.key_interval != '0) && (f1 == cfg.key_interval);
            if (key) begin
              f1 = '0;
            end
            res_nxt        = '{distance: acc_r, above_threshold: ab, shot_end: en,
                               shot_start: st, keyframe: key};
            start_rec_nxt  = sr;
            prev_above_nxt = ab;
            fsm_nxt        = f1 + PERIOD_W'(1);
          end
          res_valid_nxt = 1'b1;
          prev_cnt_nxt  = cur_cnt_r;
          cur_cnt_nxt   = '0;
          sel_nxt       = !sel_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      sel_r        <= 1'b0;
      ptr_r        <= '0;
      cur_cnt_r    <= '0;
      prev_cnt_r   <= '0;
      first_r      <= 1'b1;
      prev_above_r <= 1'b0;
      start_rec_r  <= 1'b1;
      fsm_r        <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sel_r        <= sel_nxt;
      ptr_r        <= ptr_nxt;
      cur_cnt_r    <= cur_cnt_nxt;
      prev_cnt_r   <= prev_cnt_nxt;
      first_r      <= first_nxt;
      prev_above_r <= prev_above_nxt;
      start_rec_r  <= start_rec_nxt;
      fsm_r        <= fsm_nxt;
      res_valid_r  <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
    acc_r  <= acc_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    d_r    <= d_nxt;
    s_r    <= s_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign clearing  = state_r == ST_CLEAR;

  a_frac_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    fa_busy == fb_busy)
    else $error("fraction dividers out of step");

  a_emit_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && state_nxt == ST_IDLE) |-> (!res_valid_r || res_ready))
    else $error("result overwritten before taken");

  a_no_walk_first: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK_RD |-> !first_r)
    else $error("distance walk on first frame");

  a_dual_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (we0 && we1) |-> state_r == ST_CLEAR)
    else $error("both banks written outside clearing pass");
endmodule

// ----- rtl/histogram_shot_boundary_detector.sv -----
// Top level: colour-histogram chi-square shot boundary detector.
// Depends on hsbd_pkg, hsbd_if, hsbd_front, hsbd_queue and hsbd_back.
// A pixel's bin is updated by read-modify-write of the current histogram bank
//   (registered RAM read, then write); the engine pops no new bin index until the
//   write is done. On the first frame a result follows the last pixel's bin
//   update; otherwise it follows a walk of all bins^3 entries, with two 31-bit
//   fraction divides in step for each bin set in either frame and a 26-bit term
//   divide where the fractions differ. Reset: synchronous, active low; a clearing
//   pass over the bins^3 entries (32768 by default) follows, taking no pixel until done.
module histogram_shot_boundary_detector import hsbd_pkg::*; #(
  parameter int BINS_PER_CHANNEL = BINS_PER_CHANNEL_DEF,
  parameter int MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hsbd_pix_if.sink              in_pix,
  hsbd_res_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int NB    = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
  localparam int IDX_W = $clog2(NB);

  // configuration registers; the user writes them only while idle, the block does not enforce it
  logic [DIST_W-1:0]   threshold_r;
  logic [PERIOD_W-1:0] key_interval_r;
  cfg_t                cfg;

  // front to queue
  logic             f_push, f_last, q_push_ok;
  logic [IDX_W-1:0] f_idx;
  // queue to back
  logic             q_valid, q_pop;
  logic [IDX_W:0]   q_rdata;
  // back status
  logic             clearing;
  logic             res_valid;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= THRESHOLD_RST;
      key_interval_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:    threshold_r    <= cfg_wdata;
        CFG_KEY_INTERVAL: key_interval_r <= cfg_wdata[PERIOD_W-1:0];
        default:          ;
      endcase
    end
  end

  assign cfg = '{threshold: threshold_r, key_interval: key_interval_r};

  // front end stays shut during the post-reset clearing pass
  hsbd_front #(.BINS_PER_CHANNEL(BINS_PER_CHANNEL)) u_front (
    .clk, .rst_n, .pix(in_pix), .enable(!clearing),
    .push(f_push), .push_idx(f_idx), .push_last(f_last), .push_ok(q_push_ok)
  );

  // decouples pixel intake from the histogram engine
  hsbd_queue #(.W(IDX_W + 1)) u_queue (
    .clk, .rst_n, .push(f_push), .wdata({f_last, f_idx}), .push_ok(q_push_ok),
    .pop(q_pop), .valid(q_valid), .rdata(q_rdata)
  );

  hsbd_back #(
    .BINS_PER_CHANNEL(BINS_PER_CHANNEL),
    .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_idx(q_rdata[IDX_W-1:0]), .q_last(q_rdata[IDX_W]),
    .q_pop, .cfg, .res_valid, .res_ready(out_res.ready), .res, .clearing
  );

  // result beat straight from the engine's output register
  assign out_res.valid           = res_valid;
  assign out_res.distance        = res.distance;
  assign out_res.above_threshold = res.above_threshold;
  assign out_res.shot_end        = res.shot_end;
  assign out_res.shot_start      = res.shot_start;
  assign out_res.keyframe        = res.keyframe;
endmodule
